// ===== src/prime_sieve_engine_top_macros.svh =====
// Assertion macros shared by the prime sieve engine.
// Included by the top level; depends on nothing else.
`ifndef PRIME_SIEVE_ENGINE_TOP_MACROS_SVH
`define PRIME_SIEVE_ENGINE_TOP_MACROS_SVH

// Implication in the same cycle.
`define PSE_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Delayed implication, |=> followed by ##1.
`define PSE_ASSERT_LATER(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> ##1 (post)) \
        else $error(msg);

`endif

// ===== src/pse_pkg.sv =====
// Shared constants, types and the microcode table of the prime sieve engine.
// Used by the sequencer, the datapath and the top level; depends on nothing.
package pse_pkg;

    localparam int MAX_N_DEF  = 65535;
    localparam int MAXN_W     = 24;
    localparam int LIM_W      = 16;
    localparam int CNT_W      = 17;
    localparam int I_W        = 9;
    localparam int STP_W      = 10;
    localparam int PC_W       = 4;
    localparam int COND_W     = 3;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [PC_W-1:0] S_IDLE   = 4'd0;
    localparam logic [PC_W-1:0] S_RDWAIT = 4'd1;
    localparam logic [PC_W-1:0] S_RESULT = 4'd2;
    localparam logic [PC_W-1:0] S_INIT   = 4'd3;
    localparam logic [PC_W-1:0] S_ISET   = 4'd4;
    localparam logic [PC_W-1:0] S_ITEST  = 4'd5;
    localparam logic [PC_W-1:0] S_IWAIT  = 4'd6;
    localparam logic [PC_W-1:0] S_MARK   = 4'd7;
    localparam logic [PC_W-1:0] S_INEXT  = 4'd8;
    localparam logic [PC_W-1:0] S_FIN    = 4'd9;

    localparam logic [COND_W-1:0] C_ALWAYS   = 3'd0;
    localparam logic [COND_W-1:0] C_DISPATCH = 3'd1;
    localparam logic [COND_W-1:0] C_N_END    = 3'd2;
    localparam logic [COND_W-1:0] C_SQ_GT    = 3'd3;
    localparam logic [COND_W-1:0] C_FLAG_CLR = 3'd4;
    localparam logic [COND_W-1:0] C_M_GT     = 3'd5;

    typedef struct packed {
        logic              in_ready;
        logic              we_n;
        logic              we_m;
        logic              rd_i;
        logic              n_inc;
        logic              i_init;
        logic              i_next;
        logic              m_load;
        logic              m_inc;
        logic              commit;
        logic              out_read;
        logic              out_build;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   jmp;
        logic [PC_W-1:0]   nxt;
    } t_uword;

    typedef struct packed {
        logic accept;
        logic is_read;
        logic need_build;
        logic n_end;
        logic sq_gt;
        logic flag_clr;
        logic m_gt;
    } t_flags;

    function automatic t_uword uword_at(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '0;
        case (pc)
            S_RDWAIT: begin
                w.out_read = 1'b1;
                w.cond     = C_ALWAYS;
                w.nxt      = S_IDLE;
            end
            S_RESULT: begin
                w.out_build = 1'b1;
                w.cond      = C_ALWAYS;
                w.nxt       = S_IDLE;
            end
            S_INIT: begin
                w.we_n  = 1'b1;
                w.n_inc = 1'b1;
                w.cond  = C_N_END;
                w.jmp   = S_ISET;
                w.nxt   = S_INIT;
            end
            S_ISET: begin
                w.i_init = 1'b1;
                w.cond   = C_ALWAYS;
                w.nxt    = S_ITEST;
            end
            S_ITEST: begin
                w.rd_i = 1'b1;
                w.cond = C_SQ_GT;
                w.jmp  = S_FIN;
                w.nxt  = S_IWAIT;
            end
            S_IWAIT: begin
                w.m_load = 1'b1;
                w.cond   = C_FLAG_CLR;
                w.jmp    = S_INEXT;
                w.nxt    = S_MARK;
            end
            S_MARK: begin
                w.we_m  = 1'b1;
                w.m_inc = 1'b1;
                w.cond  = C_M_GT;
                w.jmp   = S_INEXT;
                w.nxt   = S_MARK;
            end
            S_INEXT: begin
                w.i_next = 1'b1;
                w.cond   = C_ALWAYS;
                w.nxt    = S_ITEST;
            end
            S_FIN: begin
                w.commit = 1'b1;
                w.cond   = C_ALWAYS;
                w.nxt    = S_RESULT;
            end
            default: begin
                w.in_ready = 1'b1;
                w.cond     = C_DISPATCH;
                w.nxt      = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== src/pse_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module pse_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pse_seq.sv =====
// Microcode sequencer: step counter, control word table and jump logic.
// Depends on pse_pkg.
module pse_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pse_pkg::t_flags i_flags,
    output pse_pkg::t_uword o_uword
);

    logic [pse_pkg::PC_W-1:0] r_pc;
    logic [pse_pkg::PC_W-1:0] n_pc;
    pse_pkg::t_uword          uw;

    assign uw      = pse_pkg::uword_at(r_pc);
    assign o_uword = uw;

    always_comb begin
        case (uw.cond)
            pse_pkg::C_ALWAYS: begin
                n_pc = uw.nxt;
            end
            pse_pkg::C_DISPATCH: begin
                if (!i_flags.accept) begin
                    n_pc = uw.nxt;
                end else if (i_flags.is_read) begin
                    n_pc = pse_pkg::S_RDWAIT;
                end else if (i_flags.need_build) begin
                    n_pc = pse_pkg::S_INIT;
                end else begin
                    n_pc = pse_pkg::S_RESULT;
                end
            end
            pse_pkg::C_N_END: begin
                n_pc = i_flags.n_end ? uw.jmp : uw.nxt;
            end
            pse_pkg::C_SQ_GT: begin
                n_pc = i_flags.sq_gt ? uw.jmp : uw.nxt;
            end
            pse_pkg::C_FLAG_CLR: begin
                n_pc = i_flags.flag_clr ? uw.jmp : uw.nxt;
            end
            pse_pkg::C_M_GT: begin
                n_pc = i_flags.m_gt ? uw.jmp : uw.nxt;
            end
            default: begin
                n_pc = pse_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= pse_pkg::S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== src/pse_dp.sv =====
// Datapath of the prime sieve engine: counters, compares, flag memory and output register.
// Depends on pse_pkg and pse_ram; driven by the control word from pse_seq.
module pse_dp #(
    parameter int MAX_N = pse_pkg::MAX_N_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pse_pkg::t_uword                   i_uword,
    output pse_pkg::t_flags                   o_flags,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pse_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [pse_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tuser
);

    localparam int DEPTH = MAX_N + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = pse_pkg::MAXN_W;
    localparam int LW    = pse_pkg::LIM_W;
    localparam int CW    = pse_pkg::CNT_W;
    localparam int IW    = pse_pkg::I_W;
    localparam int SW    = pse_pkg::STP_W;
    localparam int PADW  = pse_pkg::OUT_DATA_W - LW - 1;

    logic [LW-1:0] in_limit;
    logic [LW-1:0] in_index;
    logic [LW-1:0] lim_sat;
    logic          accept;
    logic          init_val;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [0:0]    mem_rdata;
    logic          m_gt;

    logic [LW-1:0] r_lim;
    logic          r_err;
    logic [LW-1:0] r_n;
    logic [IW-1:0] r_i;
    logic [CW-1:0] r_sq;
    logic [SW-1:0] r_step;
    logic [CW-1:0] r_m;
    logic          r_built;
    logic [LW-1:0] r_cov;
    logic          r_out_valid;
    logic          r_out_status;
    logic          r_out_prime;
    logic [LW-1:0] r_out_limit;

    assign in_limit = s_axis_tdata[LW-1:0];
    assign in_index = s_axis_tdata[2*LW-1:LW];

    assign lim_sat = (MW'(in_limit) > MW'(MAX_N)) ? LW'(MAX_N) : in_limit;

    assign s_axis_tready = i_rst_n & i_uword.in_ready & (~r_out_valid | m_axis_tready);
    assign accept        = s_axis_tvalid & s_axis_tready;

    assign m_gt = r_m > CW'(r_lim);

    assign o_flags.accept     = accept;
    assign o_flags.is_read    = (s_axis_tuser == pse_pkg::OP_READ);
    assign o_flags.need_build = ~r_built | (lim_sat > r_cov);
    assign o_flags.n_end      = (r_n == r_lim);
    assign o_flags.sq_gt      = r_sq > CW'(r_lim);
    assign o_flags.flag_clr   = ~mem_rdata[0];
    assign o_flags.m_gt       = m_gt;

    // Two is prime; every other even number and one are not; odd numbers start set.
    assign init_val  = (r_n == LW'(2)) | (r_n[0] & (r_n != LW'(1)));
    assign mem_we    = i_uword.we_n | (i_uword.we_m & ~m_gt);
    assign mem_waddr = i_uword.we_n ? AW'(r_n) : AW'(r_m);
    assign mem_wdata = i_uword.we_n ? init_val : 1'b0;
    assign mem_raddr = i_uword.rd_i ? AW'(r_i) : AW'(in_index);

    pse_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_flags (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lim <= lim_sat;
            r_err <= ~r_built | (in_index > r_cov);
            r_n   <= '0;
        end else if (i_uword.n_inc) begin
            r_n <= r_n + LW'(1);
        end
        if (i_uword.i_init) begin
            r_i  <= IW'(3);
            r_sq <= CW'(9);
        end else if (i_uword.i_next) begin
            r_i  <= r_i + IW'(2);
            r_sq <= r_sq + CW'({r_i, 2'b00}) + CW'(4);
        end
        if (i_uword.m_load) begin
            r_step <= {r_i, 1'b0};
            r_m    <= CW'(r_i) + CW'({r_i, 1'b0});
        end else if (i_uword.m_inc) begin
            r_m <= r_m + CW'(r_step);
        end
        if (i_uword.out_read) begin
            r_out_status <= r_err;
            r_out_prime  <= ~r_err & mem_rdata[0];
            r_out_limit  <= r_cov;
        end else if (i_uword.out_build) begin
            r_out_status <= 1'b0;
            r_out_prime  <= 1'b0;
            r_out_limit  <= r_cov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_built     <= 1'b0;
            r_cov       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_uword.commit) begin
                r_built <= 1'b1;
                r_cov   <= r_lim;
            end
            if (i_uword.out_read | i_uword.out_build) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PADW{1'b0}}, r_out_limit, r_out_prime};
    assign m_axis_tuser  = r_out_status;

endmodule

// ===== src/prime_sieve_engine_top.sv =====
// Top level of the prime sieve engine: microcode sequencer and sieve datapath.
// Depends on pse_pkg, pse_seq, pse_dp and the assertion macro header.
//
//   channel   direction  tdata                              tuser
//   s_axis    in         [15:0] limit, [31:16] index        op (0 build, 1 read)
//   m_axis    out        [0] is_prime, [16:1] built_limit   status (1 error)
//
// A read, or a build that finds the table already large enough, goes from the
// transfer through S_RDWAIT or S_RESULT to the output register. A rebuild of limit L
// walks the flag memory through its single write port: S_INIT sets every flag up to
// L, then each odd i with i*i <= L passes S_ITEST, S_IWAIT and S_INEXT, with S_MARK
// for each odd multiple of i from 3i when i is still marked prime, then S_FIN and S_RESULT.
// Reset clears the control state only; the flag memory is not swept.
// A stalled result holds the output register and keeps the input from taking more.
`include "prime_sieve_engine_top_macros.svh"

module prime_sieve_engine_top #(
    parameter int MAX_N = pse_pkg::MAX_N_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [pse_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // limit, index
    input  logic                           s_axis_tuser,  // op
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [pse_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // is_prime, built_limit, zero pad
    output logic                           m_axis_tuser   // status
);

    pse_pkg::t_uword uword;
    pse_pkg::t_flags flags;
    logic            rd_accept;
    logic            out_stall;
    logic            out_err;

    pse_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uword)
    );

    pse_dp #(
        .MAX_N (MAX_N)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_uword       (uword),
        .o_flags       (flags),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    assign rd_accept = s_axis_tvalid & s_axis_tready & (s_axis_tuser == pse_pkg::OP_READ);
    assign out_stall = m_axis_tvalid & ~m_axis_tready;
    assign out_err   = m_axis_tvalid & m_axis_tuser;

    `PSE_ASSERT_LATER(a_read_result, i_clk, i_rst_n, rd_accept, m_axis_tvalid, "no read result")
    `PSE_ASSERT_IMP(a_stall_block, i_clk, i_rst_n, out_stall, !s_axis_tready, "stalled input taken")
    `PSE_ASSERT_IMP(a_err_not_prime, i_clk, i_rst_n, out_err, !m_axis_tdata[0], "prime on error")

endmodule
